// ===== rtl/core/plc_pkg.sv =====
// plc_pkg: shared types and constants for the pixel layer combiner
// beat structs, combine mode and lane op codes, lane control and result structs
// no dependencies
`default_nettype none
package plc_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int MAX_CHANNELS = 4;
  localparam int CH_IDX_BITS  = $clog2(MAX_CHANNELS);
  localparam int CNT_BITS     = 3;
  localparam int CFG_ADDR_BITS = 3;

  typedef logic [SAMPLE_BITS-1:0]   sample_t;
  typedef logic [2*SAMPLE_BITS-1:0] prod_t;

  localparam sample_t SAMPLE_FULL = '1;
  localparam prod_t   ROUND_HALF  = prod_t'(SAMPLE_FULL >> 1);

  typedef enum logic [1:0] {
    MODE_SUM   = 2'd0,
    MODE_MAX   = 2'd1,
    MODE_AVG   = 2'd2,
    MODE_BLEND = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_SUM  = 2'd0,
    OP_MAX  = 2'd1,
    OP_AVG  = 2'd2,
    OP_OVER = 2'd3
  } op_t;

  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  typedef struct packed {
    logic [15:0] acc_ch0;
    logic [15:0] acc_ch1;
    logic [15:0] acc_ch2;
    logic [15:0] acc_ch3;
    logic [15:0] src_ch0;
    logic [15:0] src_ch1;
    logic [15:0] src_ch2;
    logic [15:0] src_ch3;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] out_ch0;
    logic [15:0] out_ch1;
    logic [15:0] out_ch2;
    logic [15:0] out_ch3;
  } out_beat_t;

  typedef struct packed {
    op_t  op;
    logic used;
  } lane_ctl_t;

  typedef struct packed {
    logic    used;
    sample_t value;
  } lane_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/pixel_layer_combiner_top.sv =====
// channel   direction  handshake            payload
// in        input      start high, busy low in_data (in_beat_t)
// out       output     out_strobe, one cycle out_data (out_beat_t)
// cfg       input      apb write, pready=1  pwdata: mode at 0x0, channel count at 0x4
//
// one pixel beat accepted every cycle; busy is never raised
// result beat reaches the ports through one register each for the multiply,
// product-sum and divide-by-full-scale stages
// synchronous active-low reset clears valids and sets mode sum, four channels
// the receiver cannot stall, so nothing is held back
// depends on plc_pkg, plc_lane, plc_merge
`default_nettype none
module pixel_layer_combiner_top import plc_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire in_beat_t                 in_data,
  output logic                          out_strobe,
  output out_beat_t                     out_data,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]              pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  mode_t                mode_r;
  logic [CNT_BITS-1:0]  count_r;
  logic                 cfg_wr;
  logic                 accept;
  logic                 v1_r, v2_r;

  logic [CNT_BITS-1:0]  n_c;
  sample_t              acc_c [MAX_CHANNELS];
  sample_t              src_c [MAX_CHANNELS];
  sample_t              alpha_c;
  lane_ctl_t            ctl_c [MAX_CHANNELS];
  lane_res_t            lane_res [MAX_CHANNELS];

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_SUM;
      count_r <= CNT_BITS'(MAX_CHANNELS);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MODE:  mode_r  <= mode_t'(pwdata[1:0]);
        REG_COUNT: count_r <= pwdata[CNT_BITS-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MODE:  prdata = {30'b0, mode_r};
      REG_COUNT: prdata = {{(32-CNT_BITS){1'b0}}, count_r};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  always_comb begin
    acc_c[0] = in_data.acc_ch0;
    acc_c[1] = in_data.acc_ch1;
    acc_c[2] = in_data.acc_ch2;
    acc_c[3] = in_data.acc_ch3;
    src_c[0] = in_data.src_ch0;
    src_c[1] = in_data.src_ch1;
    src_c[2] = in_data.src_ch2;
    src_c[3] = in_data.src_ch3;

    if (count_r == '0) begin
      n_c = CNT_BITS'(1);
    end else if (count_r > CNT_BITS'(MAX_CHANNELS)) begin
      n_c = CNT_BITS'(MAX_CHANNELS);
    end else begin
      n_c = count_r;
    end

    alpha_c = src_c[CH_IDX_BITS'(n_c - 1'b1)];

    for (int k = 0; k < MAX_CHANNELS; k++) begin
      ctl_c[k].used = CNT_BITS'(k) < n_c;
      unique case (mode_r)
        MODE_SUM:   ctl_c[k].op = OP_SUM;
        MODE_MAX:   ctl_c[k].op = OP_MAX;
        MODE_AVG:   ctl_c[k].op = OP_AVG;
        MODE_BLEND: ctl_c[k].op = (CNT_BITS'(k) == n_c - 1'b1) ? OP_MAX : OP_OVER;
        default:    ctl_c[k].op = OP_SUM;
      endcase
    end
  end

  for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
    plc_lane u_lane (
      .clk   (clk),
      .ctl   (ctl_c[g]),
      .acc   (acc_c[g]),
      .src   (src_c[g]),
      .alpha (alpha_c),
      .res   (lane_res[g])
    );
  end

  plc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .lane_valid (v2_r),
    .lane_res   (lane_res),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3))
      |-> (out_strobe == $past(accept, 3)))
    else $error("result beat does not follow accepted beat by three cycles");

  a_mode_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && paddr[2] == REG_MODE) |=> (mode_r == $past(pwdata[1:0])))
    else $error("mode register not updated by write");

  a_lane0_used: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> lane_res[0].used)
    else $error("channel zero dropped from result");

endmodule
`default_nettype wire

// ===== rtl/core/plc_lane.sv =====
// plc_lane: one channel of the combiner, two register stages plus rounding divide
// sum, max, nonzero average and alpha over with division by full scale
// depends on plc_pkg
`default_nettype none
module plc_lane import plc_pkg::*; (
  input  wire logic      clk,
  input  wire lane_ctl_t ctl,
  input  wire sample_t   acc,
  input  wire sample_t   src,
  input  wire sample_t   alpha,
  output lane_res_t      res
);

  logic [SAMPLE_BITS:0] sum_c;
  sample_t              simple_c;

  op_t     op1_r, op2_r;
  logic    used1_r, used2_r;
  prod_t   p0_r, p1_r;
  sample_t simple1_r, simple2_r;
  prod_t   t_r;

  prod_t   est_sum_c;
  sample_t q_est_c;
  prod_t   q_mul_c;
  prod_t   rem_c;
  sample_t q_c;

  always_comb begin
    sum_c = {1'b0, acc} + {1'b0, src};
    case (ctl.op)
      OP_SUM: simple_c = sum_c[SAMPLE_BITS] ? SAMPLE_FULL : sum_c[SAMPLE_BITS-1:0];
      OP_AVG: begin
        if (acc == '0) begin
          simple_c = src;
        end else if (src == '0) begin
          simple_c = acc;
        end else begin
          simple_c = sample_t'((sum_c + 1'b1) >> 1);
        end
      end
      default: simple_c = (acc > src) ? acc : src;
    endcase
  end

  always_ff @(posedge clk) begin
    op1_r     <= ctl.op;
    used1_r   <= ctl.used;
    p0_r      <= acc * (SAMPLE_FULL - alpha);
    p1_r      <= src * alpha;
    simple1_r <= simple_c;
    op2_r     <= op1_r;
    used2_r   <= used1_r;
    t_r       <= p0_r + p1_r + ROUND_HALF;
    simple2_r <= simple1_r;
  end

  // divide by full scale: estimate from the high half, one correction step
  always_comb begin
    est_sum_c = t_r + prod_t'(t_r[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    q_est_c   = est_sum_c[2*SAMPLE_BITS-1:SAMPLE_BITS];
    q_mul_c   = {q_est_c, {SAMPLE_BITS{1'b0}}} - prod_t'(q_est_c);
    rem_c     = t_r - q_mul_c;
    q_c       = (rem_c >= prod_t'(SAMPLE_FULL)) ? q_est_c + 1'b1 : q_est_c;
    res.used  = used2_r;
    res.value = (op2_r == OP_OVER) ? q_c : simple2_r;
  end

endmodule
`default_nettype wire

// ===== rtl/core/plc_merge.sv =====
// plc_merge: gathers the lane results into one output beat
// clears channels not in use and registers the beat and its strobe
// depends on plc_pkg
`default_nettype none
module plc_merge import plc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      lane_valid,
  input  wire lane_res_t lane_res [MAX_CHANNELS],
  output logic           out_strobe,
  output out_beat_t      out_data
);

  sample_t   ch_c [MAX_CHANNELS];
  out_beat_t beat_nxt;
  out_beat_t beat_r;
  logic      strobe_r;

  always_comb begin
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      ch_c[k] = lane_res[k].used ? lane_res[k].value : '0;
    end
    beat_nxt.out_ch0 = ch_c[0];
    beat_nxt.out_ch1 = ch_c[1];
    beat_nxt.out_ch2 = ch_c[2];
    beat_nxt.out_ch3 = ch_c[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_data   = beat_r;

endmodule
`default_nettype wire
